// ===== rtl/adp_pkg.sv =====
`default_nettype none

package adp_pkg;

    // fixed field widths
    localparam int FIELD_W       = 16;
    localparam int ROT_W         = 4;
    localparam int COUNT_W       = 35;
    localparam int NUM_STATES    = 8;
    localparam int STATE_W       = 3;
    localparam int NUM_STARTS    = 4;
    localparam int START_W       = 2;
    localparam int DEF_WORD_BITS = 16;

    typedef logic [FIELD_W-1:0] diff_t;
    typedef logic [ROT_W-1:0]   rot_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [STATE_W-1:0] sf_state_t;

    // start states of the four chains; chain s ends in states 2s and 2s+1
    localparam sf_state_t START_STATE [NUM_STARTS] = '{3'd0, 3'd2, 3'd4, 3'd6};

    // bits fed to the s-function at the current position
    typedef struct packed {
        logic dc;
        logic dd;
        logic de;
        logic wrapped;
    } step_bits_t;

    // control of the difference shift registers
    typedef struct packed {
        logic load;
        logic shift;
    } sh_ctrl_t;

    // control of the state count registers
    typedef struct packed {
        logic      init;
        logic      step;
        sf_state_t start_state;
    } sf_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/adp_if.sv =====
`default_nettype none

// input channel: four additive differences
interface adp_in_if import adp_pkg::*;;
    logic  valid;
    logic  ready;
    diff_t diff_a;
    diff_t diff_b;
    diff_t diff_d;
    diff_t diff_e;

    modport source (output valid, output diff_a, output diff_b, output diff_d,
                    output diff_e, input ready);
    modport sink   (input valid, input diff_a, input diff_b, input diff_d,
                    input diff_e, output ready);
endinterface

// output channel: one count per item
interface adp_out_if import adp_pkg::*;;
    logic   valid;
    logic   ready;
    count_t match_count;

    modport source (output valid, output match_count, input ready);
    modport sink   (input valid, input match_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/adp_shift.sv =====
`default_nettype none

module adp_shift
    import adp_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    localparam int PW = $clog2(WORD_BITS)
)
(
    input  wire  logic          clk,
    input  wire  logic          rst_n,
    input  wire  sh_ctrl_t      ctrl,
    input  wire  diff_t         diff_a,
    input  wire  diff_t         diff_b,
    input  wire  diff_t         diff_d,
    input  wire  diff_t         diff_e,
    input  wire  logic [PW-1:0] rot_mod,
    output       step_bits_t    bits
);

    localparam int EXT_W = (WORD_BITS > FIELD_W) ? WORD_BITS : FIELD_W;

    logic [WORD_BITS-1:0] dc_sh_reg;
    logic [WORD_BITS-1:0] dd_sh_reg;
    logic [WORD_BITS-1:0] de_sh_reg;
    logic [PW-1:0]        rp_reg;

    diff_t                dc_sum;
    logic [EXT_W-1:0]     dc_ext;
    logic [EXT_W-1:0]     dd_ext;
    logic [EXT_W-1:0]     de_ext;
    logic [WORD_BITS-1:0] dc_w;
    logic [WORD_BITS-1:0] dd_w;
    logic [WORD_BITS-1:0] de_w;
    logic [WORD_BITS-1:0] dd_rot;
    logic [WORD_BITS-1:0] de_rot;

    // sum difference of the adder, cut or padded to the word
    always_comb
    begin
        dc_sum = diff_a + diff_b;
        dc_ext = EXT_W'(dc_sum);
        dd_ext = EXT_W'(diff_d);
        de_ext = EXT_W'(diff_e);
        dc_w   = dc_ext[WORD_BITS-1:0];
        dd_w   = dd_ext[WORD_BITS-1:0];
        de_w   = de_ext[WORD_BITS-1:0];
    end

    // pre-rotate d and e so that bit 0 lines up with the rotated position
    always_comb
    begin
        logic [PW:0] idx;
        idx    = '0;
        dd_rot = '0;
        de_rot = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            idx = (PW+1)'(i) + {1'b0, rot_mod};
            if (idx >= (PW+1)'(WORD_BITS))
            begin
                idx = idx - (PW+1)'(WORD_BITS);
            end
            dd_rot[i] = dd_w[idx[PW-1:0]];
            de_rot[i] = de_w[idx[PW-1:0]];
        end
    end

    // circular shift, one bit position per cycle while shift is set; a full pass restores the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_sh_reg <= '0;
            dd_sh_reg <= '0;
            de_sh_reg <= '0;
            rp_reg    <= '0;
        end
        else if (ctrl.load)
        begin
            dc_sh_reg <= dc_w;
            dd_sh_reg <= dd_rot;
            de_sh_reg <= de_rot;
            rp_reg    <= rot_mod;
        end
        else if (ctrl.shift)
        begin
            dc_sh_reg <= {dc_sh_reg[0], dc_sh_reg[WORD_BITS-1:1]};
            dd_sh_reg <= {dd_sh_reg[0], dd_sh_reg[WORD_BITS-1:1]};
            de_sh_reg <= {de_sh_reg[0], de_sh_reg[WORD_BITS-1:1]};
            if (rp_reg == PW'(WORD_BITS - 1))
            begin
                rp_reg <= '0;
            end
            else
            begin
                rp_reg <= rp_reg + PW'(1);
            end
        end
    end

    assign bits.dc      = dc_sh_reg[0];
    assign bits.dd      = dd_sh_reg[0];
    assign bits.de      = de_sh_reg[0];
    assign bits.wrapped = (rp_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/adp_sfunc.sv =====
`default_nettype none

module adp_sfunc
    import adp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sf_ctrl_t   ctrl,
    input  wire step_bits_t bits,
    output      count_t     counts [NUM_STATES]
);

    count_t cnt_reg  [NUM_STATES];
    count_t cnt_next [NUM_STATES];

    // one s-function step over all eight states and four value pairs
    // the four pairs of a state either all reach one state or reach four
    // different ones, so a state adds its count once, four times or not at all
    always_comb
    begin
        logic      s1;
        logic      s2;
        logic      s3p;
        logic      a1;
        logic      b1;
        logic      a2;
        logic      b2;
        logic      c1;
        logic      c2;
        logic      o1;
        logic      o2;
        logic [1:0] xs;
        sf_state_t  uu;
        logic [1:0] vv;
        sf_state_t  tgt;
        logic [2:0] hits [NUM_STATES][NUM_STATES];
        count_t     term [NUM_STATES][NUM_STATES];
        s1 = 1'b0; s2 = 1'b0; s3p = 1'b0; a1 = 1'b0; b1 = 1'b0; a2 = 1'b0;
        b2 = 1'b0; c1 = 1'b0; c2 = 1'b0; o1 = 1'b0; o2 = 1'b0; xs = '0;
        uu = '0; vv = '0; tgt = '0;
        for (int u = 0; u < NUM_STATES; u++)
        begin
            for (int t = 0; t < NUM_STATES; t++)
            begin
                hits[u][t] = '0;
                term[t][u] = '0;
            end
        end

        // value pairs of each state that agree with the e bit
        for (int u = 0; u < NUM_STATES; u++)
        begin
            uu  = STATE_W'(u);
            s1  = uu[0];
            // carry of d and borrow of e start afresh at the wrapped position
            s2  = bits.wrapped ? 1'b0 : uu[1];
            s3p = bits.wrapped ? 1'b1 : uu[2];
            for (int v = 0; v < 4; v++)
            begin
                vv  = 2'(v);
                a1  = vv[0];
                b1  = vv[1];
                a2  = a1 ^ bits.dc ^ s1;
                b2  = b1 ^ bits.dd ^ s2;
                o1  = (a1 & bits.dc) | (a1 & s1) | (bits.dc & s1);
                o2  = (b1 & bits.dd) | (b1 & s2) | (bits.dd & s2);
                c1  = a1 ^ b1;
                c2  = a2 ^ b2;
                xs  = {1'b0, c2} + 2'd1 - {1'b0, c1} + {1'b0, s3p};
                tgt = {xs[1], o2, o1};
                if (xs[0] == bits.de)
                begin
                    hits[u][tgt] = hits[u][tgt] + 3'd1;
                end
            end
        end

        // weighted source counts, four hits being a shift by two
        for (int t = 0; t < NUM_STATES; t++)
        begin
            for (int u = 0; u < NUM_STATES; u++)
            begin
                if (hits[u][t][2])
                begin
                    term[t][u] = {cnt_reg[u][COUNT_W-3:0], 2'b00};
                end
                else if (hits[u][t][0])
                begin
                    term[t][u] = cnt_reg[u];
                end
            end
        end

        for (int t = 0; t < NUM_STATES; t++)
        begin
            cnt_next[t] = cnt_reg[t];
        end
        if (ctrl.init)
        begin
            for (int t = 0; t < NUM_STATES; t++)
            begin
                cnt_next[t] = '0;
            end
            cnt_next[ctrl.start_state] = COUNT_W'(1);
        end
        else if (ctrl.step)
        begin
            // balanced adder tree per target state
            for (int t = 0; t < NUM_STATES; t++)
            begin
                cnt_next[t] = ((term[t][0] + term[t][1]) + (term[t][2] + term[t][3]))
                            + ((term[t][4] + term[t][5]) + (term[t][6] + term[t][7]));
            end
        end
    end

    // state count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_STATES; t++)
            begin
                cnt_reg[t] <= '0;
            end
        end
        else
        begin
            for (int t = 0; t < NUM_STATES; t++)
            begin
                cnt_reg[t] <= cnt_next[t];
            end
        end
    end

    assign counts = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/arx_additive_diff_probability_top.sv =====
// channel   | dir | beat contents
// ----------+-----+-------------------------------------------------
// in_ch     | in  | diff_a, diff_b, diff_d, diff_e (16 bits each)
// out_ch    | out | match_count (35 bits)
// cfg_wr_*  | in  | rot_amount, 4 bits, write only
//
// each item runs four chains: one s-function step per bit position on the
// eight state counts, then a sum step that adds up the chain.
// the input is not ready again until the result of the last item has gone
// into the output register.
// reset clears the counts, sequencer, output slot and rot_amount.
// the result waits in an output register; if it is still unclaimed when the
// next result is ready, the sequencer holds until the slot frees.
`default_nettype none

module arx_additive_diff_probability_top
    import adp_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_wr_en,
    input  wire rot_t     cfg_wr_data,
    adp_in_if.sink        in_ch,
    adp_out_if.source     out_ch
);

    localparam int PW          = $clog2(WORD_BITS);
    localparam int RMOD_STEPS  = ((1 << ROT_W) - 1) / WORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_SUM,
        S_HOLD
    } seq_state_t;

    seq_state_t           state_reg;
    logic [PW-1:0]        pos_reg;
    logic [START_W-1:0]   start_reg;
    count_t               total_reg;
    count_t               out_count_reg;
    logic                 out_valid_reg;
    rot_t                 rot_reg;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic [PW-1:0]        rot_mod;
    count_t               total_next;
    sh_ctrl_t             sh_ctrl;
    sf_ctrl_t             sf_ctrl;
    step_bits_t           bits;
    count_t               counts [NUM_STATES];
    sf_state_t            fin_lo;
    sf_state_t            fin_hi;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            rot_reg <= cfg_wr_data;
        end
    end

    // rotation reduced modulo the word size
    always_comb
    begin
        logic [ROT_W:0] rmod;
        rmod = {1'b0, rot_reg};
        for (int k = 0; k < RMOD_STEPS; k++)
        begin
            if (rmod >= (ROT_W+1)'(WORD_BITS))
            begin
                rmod = rmod - (ROT_W+1)'(WORD_BITS);
            end
        end
        rot_mod = PW'(rmod);
    end

    // handshakes and datapath control
    always_comb
    begin
        in_ch.ready         = (state_reg == S_IDLE);
        accept              = in_ch.valid && in_ch.ready;
        out_free            = !out_valid_reg || out_ch.ready;
        out_load            = out_free &&
                              (((state_reg == S_SUM) &&
                                (start_reg == START_W'(NUM_STARTS - 1))) ||
                               (state_reg == S_HOLD));
        sh_ctrl.load        = accept;
        sh_ctrl.shift       = (state_reg == S_RUN);
        sf_ctrl.step        = (state_reg == S_RUN);
        sf_ctrl.init        = accept ||
                              ((state_reg == S_SUM) && (start_reg != START_W'(NUM_STARTS - 1)));
        sf_ctrl.start_state = accept ? START_STATE[0]
                                     : START_STATE[START_W'(start_reg + START_W'(1))];
        fin_lo              = START_STATE[start_reg];
        fin_hi              = START_STATE[start_reg] | STATE_W'(1);
        total_next          = total_reg + counts[fin_lo] + counts[fin_hi];
    end

    adp_shift #(
        .WORD_BITS (WORD_BITS)
    ) u_shift (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sh_ctrl),
        .diff_a  (in_ch.diff_a),
        .diff_b  (in_ch.diff_b),
        .diff_d  (in_ch.diff_d),
        .diff_e  (in_ch.diff_e),
        .rot_mod (rot_mod),
        .bits    (bits)
    );

    adp_sfunc u_sfunc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sf_ctrl),
        .bits   (bits),
        .counts (counts)
    );

    // sequencer, chain sum and output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            start_reg     <= '0;
            total_reg     <= '0;
            out_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pos_reg   <= '0;
                        start_reg <= '0;
                        total_reg <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (pos_reg == PW'(WORD_BITS - 1))
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + PW'(1);
                    end
                end
                S_SUM:
                begin
                    total_reg <= total_next;
                    if (start_reg == START_W'(NUM_STARTS - 1))
                    begin
                        if (out_free)
                        begin
                            out_count_reg <= total_next;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_HOLD;
                        end
                    end
                    else
                    begin
                        start_reg <= start_reg + START_W'(1);
                        state_reg <= S_RUN;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_count_reg <= total_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.match_count = out_count_reg;

`ifndef SYNTHESIS
    // an accepted beat keeps the engine busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken again straight after a beat");

    // bit position stays inside the word while stepping
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (pos_reg <= PW'(WORD_BITS - 1)))
        else $error("bit position beyond word size");

    // the sequencer only waits while the output slot is occupied
    a_hold_needs_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> out_valid_reg)
        else $error("holding a result with a free output slot");
`endif

endmodule

`default_nettype wire
